FILE: src/imtr_pkg.sv
package imtr_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int ITER              = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS
                                                                       : ATAN_LEN;
    localparam int STG_W             = 5;
    localparam int ROOT_W            = 16;
    localparam int REM_W             = 20;
    localparam int RAD_W             = 32;
    localparam int XY_W              = 27;
    localparam int Z_W               = 24;
    localparam int ANGLE_LIMIT       = 11520;

    typedef enum logic [1:0] {
        REG_X_OFS = 2'd0,
        REG_Y_OFS = 2'd1,
        REG_Z_OFS = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [13:0]        qx;
        logic [13:0]        qy;
        logic [13:0]        qz;
        logic               nx;
        logic               ny;
        logic               nz;
        logic               zero;
    } side_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STG_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 24'sd1474560;
            5'd1:  v = 24'sd870484;
            5'd2:  v = 24'sd459940;
            5'd3:  v = 24'sd233473;
            5'd4:  v = 24'sd117189;
            5'd5:  v = 24'sd58652;
            5'd6:  v = 24'sd29333;
            5'd7:  v = 24'sd14667;
            5'd8:  v = 24'sd7334;
            5'd9:  v = 24'sd3667;
            5'd10: v = 24'sd1833;
            5'd11: v = 24'sd917;
            5'd12: v = 24'sd458;
            5'd13: v = 24'sd229;
            5'd14: v = 24'sd115;
            5'd15: v = 24'sd57;
            5'd16: v = 24'sd29;
            5'd17: v = 24'sd14;
            5'd18: v = 24'sd7;
            5'd19: v = 24'sd4;
            5'd20: v = 24'sd2;
            5'd21: v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/imu_tilt_and_rate_convert.sv
// channel   signals                                   dir
// -------   ---------------------------------------   ---
// sample    start, busy, raw_accel_*, raw_gyro_*      in/out
// result    done, roll/pitch_angle, *_rate, accel_*   out
// config    psel, penable, pwrite, paddr, pwdata,     in/out
//           prdata, pready
// One word per cycle; busy is always low. From start to done a word passes
// 3 front stages, 16 square-root cells, one CORDIC cell per iteration and
// one output stage. Reset clears valids and loads the default offsets.
// The receiver cannot stall: done is high for one cycle per word.
module imu_tilt_and_rate_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] raw_accel_x,
    input  logic signed [15:0] raw_accel_y,
    input  logic signed [15:0] raw_accel_z,
    input  logic signed [15:0] raw_gyro_x,
    input  logic signed [15:0] raw_gyro_y,
    input  logic signed [15:0] raw_gyro_z,
    output logic               done,
    output logic signed [14:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [13:0] roll_rate,
    output logic signed [13:0] pitch_rate,
    output logic signed [13:0] yaw_rate,
    output logic signed [15:0] accel_x_corrected,
    output logic signed [15:0] accel_y_corrected,
    output logic signed [15:0] accel_z_corrected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import imtr_pkg::*;

    localparam int SIDE_LEN = ROOT_W + ITER + 1;
    localparam logic [15:0] RECIP = 16'd64035;

    // configuration
    logic signed [9:0] xofs_reg, yofs_reg, zofs_reg;
    reg_idx_t          widx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xofs_reg <= -10'sd82;
            yofs_reg <= 10'sd0;
            zofs_reg <= 10'sd164;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_X_OFS: xofs_reg <= pwdata[9:0];
                REG_Y_OFS: yofs_reg <= pwdata[9:0];
                REG_Z_OFS: zofs_reg <= pwdata[9:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_X_OFS: prdata = 32'(xofs_reg);
            REG_Y_OFS: prdata = 32'(yofs_reg);
            REG_Z_OFS: prdata = 32'(zofs_reg);
            default:   prdata = 32'd0;
        endcase
    end

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [9:0] b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        if (s > 17'sd32767)
            return 16'sh7fff;
        else if (s < -17'sd32768)
            return 16'sh8000;
        return s[15:0];
    endfunction

    function automatic logic [21:0] rate_num(input logic signed [15:0] r);
        logic signed [16:0] w;
        logic [16:0]        m;
        w = 17'(r);
        m = w[16] ? 17'(-w) : 17'(w);
        return 22'({m, 6'd0}) + 22'd131;
    endfunction

    // stage 1
    logic               v1_reg;
    logic signed [15:0] ax1_reg, ay1_reg, az1_reg;
    logic [21:0]        nx1_reg, ny1_reg, nz1_reg;
    logic               gx1_reg, gy1_reg, gz1_reg;

    always_ff @(posedge clk)
    begin
        ax1_reg <= sat_add(raw_accel_x, xofs_reg);
        ay1_reg <= sat_add(raw_accel_y, yofs_reg);
        az1_reg <= sat_add(raw_accel_z, zofs_reg);
        nx1_reg <= rate_num(raw_gyro_x);
        ny1_reg <= rate_num(raw_gyro_y);
        nz1_reg <= rate_num(raw_gyro_z);
        gx1_reg <= raw_gyro_x[15];
        gy1_reg <= raw_gyro_y[15];
        gz1_reg <= raw_gyro_z[15];
    end

    // stage 2: squares and reciprocal products
    logic               v2_reg;
    logic signed [15:0] ax2_reg, ay2_reg, az2_reg;
    logic signed [31:0] sx2_reg, sy2_reg, sz2_reg;
    logic [37:0]        px2_reg, py2_reg, pz2_reg;
    logic [21:0]        nx2_reg, ny2_reg, nz2_reg;
    logic               gx2_reg, gy2_reg, gz2_reg;

    always_ff @(posedge clk)
    begin
        ax2_reg <= ax1_reg;
        ay2_reg <= ay1_reg;
        az2_reg <= az1_reg;
        sx2_reg <= ax1_reg * ax1_reg;
        sy2_reg <= ay1_reg * ay1_reg;
        sz2_reg <= az1_reg * az1_reg;
        px2_reg <= 38'(nx1_reg) * 38'(RECIP);
        py2_reg <= 38'(ny1_reg) * 38'(RECIP);
        pz2_reg <= 38'(nz1_reg) * 38'(RECIP);
        nx2_reg <= nx1_reg;
        ny2_reg <= ny1_reg;
        nz2_reg <= nz1_reg;
        gx2_reg <= gx1_reg;
        gy2_reg <= gy1_reg;
        gz2_reg <= gz1_reg;
    end

    function automatic logic [13:0] quot_fix(input logic [37:0] p, input logic [21:0] n);
        logic [13:0] q0;
        logic [22:0] lim;
        q0  = p[37:24];
        lim = 23'(15'(q0) + 15'd1) * 23'd262;
        return (23'(n) >= lim) ? q0 + 14'd1 : q0;
    endfunction

    // stage 3 and side line
    side_t             side_reg [0:SIDE_LEN-1];
    logic [SIDE_LEN-1:0] vld_reg;
    logic [RAD_W-1:0]  rad_r [0:ROOT_W];
    logic [RAD_W-1:0]  rad_p [0:ROOT_W];
    logic [REM_W-1:0]  rem_r [0:ROOT_W];
    logic [REM_W-1:0]  rem_p [0:ROOT_W];
    logic [ROOT_W-1:0] rt_r  [0:ROOT_W];
    logic [ROOT_W-1:0] rt_p  [0:ROOT_W];
    logic [RAD_W-1:0]  sum_r_reg, sum_p_reg;

    always_ff @(posedge clk)
    begin
        sum_r_reg        <= RAD_W'(sx2_reg[30:0]) + RAD_W'(sz2_reg[30:0]);
        sum_p_reg        <= RAD_W'(sy2_reg[30:0]) + RAD_W'(sz2_reg[30:0]);
        side_reg[0].ax   <= ax2_reg;
        side_reg[0].ay   <= ay2_reg;
        side_reg[0].az   <= az2_reg;
        side_reg[0].qx   <= quot_fix(px2_reg, nx2_reg);
        side_reg[0].qy   <= quot_fix(py2_reg, ny2_reg);
        side_reg[0].qz   <= quot_fix(pz2_reg, nz2_reg);
        side_reg[0].nx   <= gx2_reg;
        side_reg[0].ny   <= gy2_reg;
        side_reg[0].nz   <= gz2_reg;
        side_reg[0].zero <= (ax2_reg == 16'sd0) && (ay2_reg == 16'sd0) && (az2_reg == 16'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            v1_reg  <= start;
            v2_reg  <= v1_reg;
            vld_reg <= {vld_reg[SIDE_LEN-2:0], v2_reg};
        end
    end

    genvar k;
    generate
        for (k = 1; k < SIDE_LEN; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    endgenerate

    // square-root chain
    assign rad_r[0] = sum_r_reg;
    assign rad_p[0] = sum_p_reg;
    assign rem_r[0] = '0;
    assign rem_p[0] = '0;
    assign rt_r[0]  = '0;
    assign rt_p[0]  = '0;

    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_sqrt
            imtr_sqrt_cell u_sq_r (
                .clk      (clk),
                .rad_in   (rad_r[k]),
                .rem_in   (rem_r[k]),
                .root_in  (rt_r[k]),
                .rad_out  (rad_r[k+1]),
                .rem_out  (rem_r[k+1]),
                .root_out (rt_r[k+1])
            );
            imtr_sqrt_cell u_sq_p (
                .clk      (clk),
                .rad_in   (rad_p[k]),
                .rem_in   (rem_p[k]),
                .root_in  (rt_p[k]),
                .rad_out  (rad_p[k+1]),
                .rem_out  (rem_p[k+1]),
                .root_out (rt_p[k+1])
            );
        end
    endgenerate

    // CORDIC chain
    logic signed [XY_W-1:0] xr [0:ITER];
    logic signed [XY_W-1:0] yr [0:ITER];
    logic signed [Z_W-1:0]  zr [0:ITER];
    logic signed [XY_W-1:0] xp [0:ITER];
    logic signed [XY_W-1:0] yp [0:ITER];
    logic signed [Z_W-1:0]  zp [0:ITER];

    assign xr[0] = XY_W'({rt_r[ROOT_W], 8'd0});
    assign xp[0] = XY_W'({rt_p[ROOT_W], 8'd0});
    assign yr[0] = XY_W'(side_reg[ROOT_W].ay) <<< 8;
    assign yp[0] = XY_W'(side_reg[ROOT_W].ax) <<< 8;
    assign zr[0] = '0;
    assign zp[0] = '0;

    generate
        for (k = 0; k < ITER; k++)
        begin : g_cordic
            imtr_cordic_cell u_cr (
                .clk   (clk),
                .stage (STG_W'(k)),
                .x_in  (xr[k]),
                .y_in  (yr[k]),
                .z_in  (zr[k]),
                .x_out (xr[k+1]),
                .y_out (yr[k+1]),
                .z_out (zr[k+1])
            );
            imtr_cordic_cell u_cp (
                .clk   (clk),
                .stage (STG_W'(k)),
                .x_in  (xp[k]),
                .y_in  (yp[k]),
                .z_in  (zp[k]),
                .x_out (xp[k+1]),
                .y_out (yp[k+1]),
                .z_out (zp[k+1])
            );
        end
    endgenerate

    // output stage
    function automatic logic signed [14:0] to_angle(input logic signed [Z_W-1:0] z);
        logic signed [Z_W:0]  s;
        logic signed [16:0]   r;
        s = (Z_W+1)'(z) + (Z_W+1)'(128);
        r = s[Z_W:8];
        if (r > 17'sd11520)
            return 15'sd11520;
        else if (r < -17'sd11520)
            return -15'sd11520;
        return r[14:0];
    endfunction

    function automatic logic signed [13:0] signed_rate(input logic [13:0] q, input logic n);
        return n ? -$signed(q) : $signed(q);
    endfunction

    side_t              so;
    logic               done_reg;
    logic signed [14:0] roll_reg, pitch_reg;
    logic signed [13:0] rr_reg, pr_reg, yr_reg;
    logic signed [15:0] cx_reg, cy_reg, cz_reg;

    assign so = side_reg[SIDE_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[SIDE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        roll_reg  <= so.zero ? 15'sd0 : to_angle(zr[ITER]);
        pitch_reg <= so.zero ? 15'sd0 : -to_angle(zp[ITER]);
        rr_reg    <= signed_rate(so.qx, so.nx);
        pr_reg    <= signed_rate(so.qy, so.ny);
        yr_reg    <= signed_rate(so.qz, so.nz);
        cx_reg    <= so.ax;
        cy_reg    <= so.ay;
        cz_reg    <= so.az;
    end

    assign done              = done_reg;
    assign roll_angle        = roll_reg;
    assign pitch_angle       = pitch_reg;
    assign roll_rate         = rr_reg;
    assign pitch_rate        = pr_reg;
    assign yaw_rate          = yr_reg;
    assign accel_x_corrected = cx_reg;
    assign accel_y_corrected = cy_reg;
    assign accel_z_corrected = cz_reg;

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (roll_angle <= 15'sd11520) && (roll_angle >= -15'sd11520))
        else $error("roll angle out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= 15'sd11520) && (pitch_angle >= -15'sd11520))
        else $error("pitch angle out of range");

    a_zero_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accel_x_corrected == 16'sd0 && accel_y_corrected == 16'sd0
         && accel_z_corrected == 16'sd0) |-> (roll_angle == 15'sd0 && pitch_angle == 15'sd0))
        else $error("nonzero angle for zero vector");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (roll_rate <= 14'sd8006) && (roll_rate >= -14'sd8006))
        else $error("roll rate out of range");
endmodule

FILE: src/imtr_sqrt_cell.sv
module imtr_sqrt_cell (
    input  logic                       clk,
    input  logic [imtr_pkg::RAD_W-1:0]  rad_in,
    input  logic [imtr_pkg::REM_W-1:0]  rem_in,
    input  logic [imtr_pkg::ROOT_W-1:0] root_in,
    output logic [imtr_pkg::RAD_W-1:0]  rad_out,
    output logic [imtr_pkg::REM_W-1:0]  rem_out,
    output logic [imtr_pkg::ROOT_W-1:0] root_out
);
    import imtr_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_next, part;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  trial;

    always_comb
    begin
        part  = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        trial = REM_W'({root_in, 2'b01});
        if (part >= trial)
        begin
            rem_next  = part - trial;
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = part;
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

FILE: src/imtr_cordic_cell.sv
module imtr_cordic_cell (
    input  logic                              clk,
    input  logic [imtr_pkg::STG_W-1:0]        stage,
    input  logic signed [imtr_pkg::XY_W-1:0]  x_in,
    input  logic signed [imtr_pkg::XY_W-1:0]  y_in,
    input  logic signed [imtr_pkg::Z_W-1:0]   z_in,
    output logic signed [imtr_pkg::XY_W-1:0]  x_out,
    output logic signed [imtr_pkg::XY_W-1:0]  y_out,
    output logic signed [imtr_pkg::Z_W-1:0]   z_out
);
    import imtr_pkg::*;

    logic signed [XY_W-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [Z_W-1:0]  z_reg, z_next, ang;

    always_comb
    begin
        xs  = x_in >>> stage;
        ys  = y_in >>> stage;
        ang = atan_entry(stage);
        if (!y_in[XY_W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
